/* rtl/core/wpm_pkg.sv */
`timescale 1ns / 1ps

package wpm_pkg;

	// pattern capacity and derived widths
	localparam int MAX_PATTERN = 64;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

	// special pattern bytes
	localparam logic [7:0] STAR_BYTE = 8'd42;
	localparam logic [7:0] ANY_BYTE  = 8'd63;

	// command codes on the input channel
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_TEXT   = 2'd2,
		CMD_END    = 2'd3
	} cmd_t;

	// control broadcast from the top level to every cell
	typedef struct packed {
		logic             clear;
		logic             arm;
		logic             advance;
		logic             store;
		logic [7:0]       symbol;
		logic [LEN_W-1:0] length;
	} cell_ctl_t;

endpackage

/* rtl/core/wpm_cell.sv */
`timescale 1ns / 1ps

module wpm_cell
	import wpm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [LEN_W-1:0] index,
	input  logic             left_col,
	input  logic             left_cand,
	output logic             col,
	output logic             cand,
	output logic             hit_term
);

	logic [7:0] pat_q;
	logic       col_q;
	logic       active;
	logic       last;
	logic       first;
	logic       wr;
	logic       is_star;
	logic       byte_ok;
	logic       next_adv;
	logic       arm_val;

	// position of this cell against the stored pattern length
	assign active = (index <= ctl.length);
	assign last   = (index == ctl.length);
	assign first  = (index == LEN_W'(1));
	assign wr     = ctl.store && (index == ctl.length + LEN_W'(1));

	// compare of the stored byte against the text byte
	assign is_star = (pat_q == STAR_BYTE);
	assign byte_ok = (pat_q == ANY_BYTE) || (pat_q == ctl.symbol);
	assign cand    = byte_ok && left_col;

	// stars never sit next to each other, so the left candidate is the left result
	always_comb begin
		if (!active) begin
			next_adv = 1'b0;
		end else if (is_star) begin
			next_adv = col_q || left_cand;
		end else begin
			next_adv = cand;
		end
	end

	// re-armed column: only a leading star extends the empty-prefix match
	always_comb begin
		if (!first || ctl.clear) begin
			arm_val = 1'b0;
		end else if (wr) begin
			arm_val = (ctl.symbol == STAR_BYTE);
		end else begin
			arm_val = active && is_star;
		end
	end

	// pattern byte of this position
	always_ff @(posedge clk) begin
		if (wr) begin
			pat_q <= ctl.symbol;
		end
	end

	// match bit of this position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 1'b0;
		end else if (ctl.arm) begin
			col_q <= arm_val;
		end else if (ctl.advance) begin
			col_q <= next_adv;
		end
	end

	assign col      = col_q;
	assign hit_term = last && col_q;

endmodule

/* rtl/core/wildcard_pattern_matcher_top.sv */
`timescale 1ns / 1ps
// channel | handshake            | payload
// --------+----------------------+---------------------------------
// input   | in_valid / in_stall  | command[1:0], symbol[7:0]
// output  | out_valid / out_stall| matched, pattern_overflow
//
// An item can be accepted on every clock while the input is not stalled.
// The match column lives in a chain of 64 cells, one per pattern position,
// each updating its bit from its left neighbor in the same cycle.
// Only end of text gives a transfer on the output; it is held in one
// output register, and input stalls only while that register is full and stalled.
// Reset empties the pattern and arms the column; no clearing pass is needed.

module wildcard_pattern_matcher_top
	import wpm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic       pattern_overflow
);

	logic [LEN_W-1:0]       len_q;
	logic                   prev_star_q;
	logic                   ovf_q;
	logic                   col0_q;
	logic                   out_valid_q;
	logic                   matched_q;
	logic                   ovf_out_q;
	logic                   accept;
	logic                   sym_star;
	logic                   collapse;
	logic                   full;
	logic                   hit;
	cmd_t                   cmd;
	cell_ctl_t              ctl;
	logic [MAX_PATTERN:0]   col_chain;
	logic [MAX_PATTERN:0]   cand_chain;
	logic [MAX_PATTERN-1:0] hit_terms;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign cmd      = cmd_t'(command);
	assign sym_star = (symbol == STAR_BYTE);
	assign collapse = sym_star && prev_star_q;
	assign full     = (len_q == LEN_W'(MAX_PATTERN));

	// command decode into the cell broadcast
	always_comb begin
		ctl         = '0;
		ctl.symbol  = symbol;
		ctl.length  = len_q;
		if (accept) begin
			unique case (cmd)
				CMD_CLEAR: begin
					ctl.clear = 1'b1;
					ctl.arm   = 1'b1;
				end
				CMD_APPEND: begin
					ctl.arm   = !collapse;
					ctl.store = !collapse && !full;
				end
				CMD_TEXT: begin
					ctl.advance = 1'b1;
				end
				CMD_END: begin
					ctl.arm = 1'b1;
				end
				default: begin
					ctl.arm = 1'b0;
				end
			endcase
		end
	end

	// pattern length, star tracking and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			prev_star_q <= 1'b0;
			ovf_q       <= 1'b0;
		end else if (accept) begin
			if (cmd == CMD_CLEAR) begin
				len_q       <= '0;
				prev_star_q <= 1'b0;
				ovf_q       <= 1'b0;
			end else if (cmd == CMD_APPEND && !collapse) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + LEN_W'(1);
				end
				prev_star_q <= sym_star;
			end
		end
	end

	// empty-prefix entry of the column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col0_q <= 1'b1;
		end else if (ctl.arm) begin
			col0_q <= 1'b1;
		end else if (ctl.advance) begin
			col0_q <= 1'b0;
		end
	end

	assign col_chain[0]  = col0_q;
	assign cand_chain[0] = 1'b0;

	// chain of match cells
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		wpm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.index     (LEN_W'(i + 1)),
			.left_col  (col_chain[i]),
			.left_cand (cand_chain[i]),
			.col       (col_chain[i + 1]),
			.cand      (cand_chain[i + 1]),
			.hit_term  (hit_terms[i])
		);
	end

	// match bit at the pattern length
	assign hit = (len_q == '0) ? col0_q : (|hit_terms);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && cmd == CMD_END) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_END) begin
			matched_q <= hit && !ovf_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = ovf_out_q;

`ifndef SYNTH
	// overflow only happens with a full pattern
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == LEN_W'(MAX_PATTERN)))
		else $error("overflow flag set with room left");

	// a clear transfer empties the pattern and drops overflow
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_CLEAR) |=> (len_q == '0 && !ovf_q && !prev_star_q))
		else $error("clear did not empty the pattern");

	// a remembered star implies something was appended
	a_star_len: assert property (@(posedge clk) disable iff (!arst_n)
		prev_star_q |-> (len_q != '0))
		else $error("star remembered with an empty pattern");

	// end of text always produces a result
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_END) |=> out_valid_q)
		else $error("end of text gave no result");

	// a reported match never comes with overflow
	a_match_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(matched_q && ovf_out_q))
		else $error("match reported with overflow");
`endif

endmodule
